// File: src/ssr_pkg.sv
// Shared types, constants and the segment decoder for the seven-segment raster block.
// Used by ssr_render and scaled_seven_segment_raster_top; depends on nothing else.
package ssr_pkg;

	localparam int MAX_DIGITS = 16;
	localparam int MAX_SCALE  = 15;

	localparam int SCALE_W = 4;
	localparam int COUNT_W = 5;
	localparam int SLOT_W  = 4;
	localparam int DIGIT_W = 4;
	localparam int GLYPH_W = 2;
	localparam int ROW_W   = 6;
	localparam int COL_W   = 5;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd2;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 2'd0;
	localparam logic [GLYPH_W-1:0] GLYPH_HBAR  = 2'd1;
	localparam logic [GLYPH_W-1:0] GLYPH_VBAR  = 2'd2;

	// Register index as decoded from paddr[2].
	localparam logic REG_SCALE = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	// Segment bit positions, a in bit 0 through g in bit 6.
	localparam int SEG_A = 0;
	localparam int SEG_B = 1;
	localparam int SEG_C = 2;
	localparam int SEG_D = 3;
	localparam int SEG_E = 4;
	localparam int SEG_F = 5;
	localparam int SEG_G = 6;

	typedef struct packed {
		logic               command;
		logic [SLOT_W-1:0]  digit_slot;
		logic [DIGIT_W-1:0] digit_value;
	} ssr_item_t;

	typedef struct packed {
		logic [GLYPH_W-1:0] glyph;
		logic               row_end;
		logic               frame_end;
	} ssr_result_t;

	// Digits above nine light no segments.
	function automatic logic [6:0] seg_decode(input logic [DIGIT_W-1:0] d);
		logic [6:0] segs;
		case (d)
			4'd0:    segs = 7'h3F;
			4'd1:    segs = 7'h06;
			4'd2:    segs = 7'h5B;
			4'd3:    segs = 7'h4F;
			4'd4:    segs = 7'h66;
			4'd5:    segs = 7'h6D;
			4'd6:    segs = 7'h7D;
			4'd7:    segs = 7'h07;
			4'd8:    segs = 7'h7F;
			4'd9:    segs = 7'h6F;
			default: segs = 7'h00;
		endcase
		return segs;
	endfunction

endpackage

// File: src/ssr_render.sv
// Raster cursors, digit store and per-cell glyph logic of the seven-segment raster block.
// Depends on ssr_pkg; instantiated by scaled_seven_segment_raster_top.
module ssr_render (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  ssr_pkg::ssr_item_t            item,
	input  logic [ssr_pkg::SCALE_W-1:0]   scale,
	input  logic [ssr_pkg::COUNT_W-1:0]   digit_count,
	output ssr_pkg::ssr_result_t          result
);
	import ssr_pkg::*;

	logic [DIGIT_W-1:0] digit_store_q [MAX_DIGITS];
	logic [ROW_W-1:0]   row_cursor_q;
	logic [COL_W-1:0]   col_cursor_q;
	logic [SLOT_W-1:0]  slot_cursor_q;

	logic [SCALE_W-1:0] s_eff;
	logic [COUNT_W-1:0] n_eff;
	logic [ROW_W-1:0]   s6, s_p1, r_mid, r_last, row6, col6;
	logic [6:0]         segs;
	logic               mid_col, col_wrap, row_end, frame_end;
	logic [GLYPH_W-1:0] glyph;

	always_comb begin
		s_eff = scale;
		if (scale == '0) begin
			s_eff = SCALE_W'(1);
		end else if (32'(scale) > MAX_SCALE) begin
			s_eff = SCALE_W'(MAX_SCALE);
		end
		n_eff = digit_count;
		if (digit_count == '0) begin
			n_eff = COUNT_W'(1);
		end else if (32'(digit_count) > MAX_DIGITS) begin
			n_eff = COUNT_W'(MAX_DIGITS);
		end
	end

	always_comb begin
		s6     = ROW_W'(s_eff);
		s_p1   = s6 + ROW_W'(1);
		r_mid  = s_p1;
		r_last = {s6[ROW_W-2:0], 1'b0} + ROW_W'(2);
		row6   = row_cursor_q;
		col6   = ROW_W'(col_cursor_q);

		segs = 7'h00;
		if (COUNT_W'(slot_cursor_q) < n_eff) begin
			segs = seg_decode(digit_store_q[slot_cursor_q]);
		end

		mid_col = (col6 >= ROW_W'(1)) && (col6 <= s6);
		glyph   = GLYPH_BLANK;
		if (col6 > s_p1 || row6 > r_last) begin
			glyph = GLYPH_BLANK;
		end else if (row6 == '0) begin
			if (mid_col && segs[SEG_A]) glyph = GLYPH_HBAR;
		end else if (row6 == r_mid) begin
			if (mid_col && segs[SEG_G]) glyph = GLYPH_HBAR;
		end else if (row6 == r_last) begin
			if (mid_col && segs[SEG_D]) glyph = GLYPH_HBAR;
		end else if (row6 <= s6) begin
			if ((col6 == '0 && segs[SEG_F]) || (col6 == s_p1 && segs[SEG_B])) begin
				glyph = GLYPH_VBAR;
			end
		end else begin
			if ((col6 == '0 && segs[SEG_E]) || (col6 == s_p1 && segs[SEG_C])) begin
				glyph = GLYPH_VBAR;
			end
		end

		// The blank gap column is the last one of a digit cell.
		col_wrap  = col6 >= (s6 + ROW_W'(2));
		row_end   = ((COUNT_W'(slot_cursor_q) + COUNT_W'(1)) >= n_eff) && col_wrap;
		frame_end = row_end && (row6 >= r_last);

		result.glyph     = glyph;
		result.row_end   = row_end;
		result.frame_end = frame_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIGITS; i++) begin
				digit_store_q[i] <= '0;
			end
			row_cursor_q  <= '0;
			col_cursor_q  <= '0;
			slot_cursor_q <= '0;
		end else if (go) begin
			if (item.command == CMD_WRITE) begin
				digit_store_q[item.digit_slot] <= item.digit_value;
			end else if (row_end) begin
				col_cursor_q  <= '0;
				slot_cursor_q <= '0;
				row_cursor_q  <= frame_end ? '0 : row_cursor_q + ROW_W'(1);
			end else if (col_wrap) begin
				col_cursor_q  <= '0;
				slot_cursor_q <= slot_cursor_q + SLOT_W'(1);
			end else begin
				col_cursor_q <= col_cursor_q + COL_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_cursor_q) <= 2 * MAX_SCALE + 2)
		else $error("row cursor beyond tallest frame");
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_cursor_q) <= MAX_SCALE + 2)
		else $error("column cursor beyond widest cell");
	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		go && item.command == CMD_TICK && row_end |=> col_cursor_q == '0 && slot_cursor_q == '0)
		else $error("cursor did not wrap at row end");
	a_write_holds: assert property (@(posedge clk) disable iff (!arst_n)
		go && item.command == CMD_WRITE |=> $stable(row_cursor_q) && $stable(col_cursor_q))
		else $error("digit write moved the raster cursor");
`endif

endmodule

// File: src/scaled_seven_segment_raster_top.sv
// Top level of the scaled seven-segment raster block: handshakes, registers, result stage.
// Depends on ssr_pkg and ssr_render.

// The block accepts one item per clock while item_stall is low and returns one raster cell
// for every tick item, none for a digit write; a tick's cell passes from the item register
// to a result register, which holds it on the result port, so that a new item is taken in
// every cycle while that register is free or being emptied. The raster cursor is read and
// advanced in the same cycle, which sets this rate. Digit writes and register writes take
// effect for the next tick; scale and digit_count are clamped to their legal ranges before
// use.
module scaled_seven_segment_raster_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic                          command,
	input  logic [ssr_pkg::SLOT_W-1:0]    digit_slot,
	input  logic [ssr_pkg::DIGIT_W-1:0]   digit_value,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [ssr_pkg::GLYPH_W-1:0]   glyph,
	output logic                          row_end,
	output logic                          frame_end,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import ssr_pkg::*;

	logic [SCALE_W-1:0] scale_q;
	logic [COUNT_W-1:0] digit_count_q;

	logic        valid_s1;
	ssr_item_t   item_s1;
	logic        go_s1, tick_go, out_free;
	ssr_result_t render_out;

	logic        valid_s2;
	ssr_result_t result_s2;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q       <= SCALE_RESET;
			digit_count_q <= COUNT_RESET;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_SCALE: scale_q       <= pwdata[SCALE_W-1:0];
				REG_COUNT: digit_count_q <= pwdata[COUNT_W-1:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_SCALE: prdata = 32'(scale_q);
			REG_COUNT: prdata = 32'(digit_count_q);
			default:   prdata = '0;
		endcase
	end

	// A write item never needs the result stage, so it drains even under stall.
	assign out_free   = !valid_s2 || !result_stall;
	assign go_s1      = valid_s1 && (item_s1.command == CMD_WRITE || out_free);
	assign tick_go    = go_s1 && item_s1.command == CMD_TICK;
	assign item_stall = valid_s1 && !go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!item_stall) begin
				valid_s1 <= item_valid;
			end
			if (tick_go) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1.command     <= command;
			item_s1.digit_slot  <= digit_slot;
			item_s1.digit_value <= digit_value;
		end
		if (tick_go) begin
			result_s2 <= render_out;
		end
	end

	ssr_render u_render (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go_s1),
		.item        (item_s1),
		.scale       (scale_q),
		.digit_count (digit_count_q),
		.result      (render_out)
	);

	assign result_valid = valid_s2;
	assign glyph        = result_s2.glyph;
	assign row_end      = result_s2.row_end;
	assign frame_end    = result_s2.frame_end;

`ifndef SYNTHESIS
	a_frame_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !frame_end || row_end)
		else $error("frame end without row end");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && item_s1.command == CMD_TICK && result_valid && result_stall)
		else $error("input stalled without a blocked result");
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick_go |=> result_valid)
		else $error("tick item produced no result");
`endif

endmodule
